[design/osa_edit_distance_top_assert.svh]
// Assertion macros for the edit distance block.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef OSA_EDIT_DISTANCE_TOP_ASSERT_SVH
`define OSA_EDIT_DISTANCE_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define OSA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define OSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/osa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osa_pkg
// Shared widths, function codes and the controller/datapath command and
// status structs.
// ----------------------------------------------------------------------------
package osa_pkg;

    localparam int MAX_LEN_DEF = 64;
    localparam int FUNC_W      = 2;
    localparam int SYM_W       = 8;
    localparam int DIST_W      = 7;
    localparam int DIST_SAT    = 127;

    localparam logic [FUNC_W-1:0] FUNC_FIRST  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SECOND = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_END    = 2'd2;

    typedef struct packed {
        logic load_first;
        logic set_ovf;
        logic row_start;
        logic rd;
        logic cmp;
        logic row_end;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic first_zero;
        logic first_full;
        logic second_zero;
        logic second_full;
        logic last_col;
    } sts_t;

endpackage

[design/osa_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osa_in_if
// Input channel: function code and symbol byte per beat.
// ----------------------------------------------------------------------------
interface osa_in_if;
    import osa_pkg::*;

    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [SYM_W-1:0]  symbol;

    modport source (output valid, output func, output symbol, input ready);
    modport sink   (input valid, input func, input symbol, output ready);

endinterface

[design/osa_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osa_out_if
// Output channel: distance and overflow flag per beat.
// ----------------------------------------------------------------------------
interface osa_out_if;
    import osa_pkg::*;

    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance;
    logic              overflow;

    modport source (output valid, output distance, output overflow, input ready);
    modport sink   (input valid, input distance, input overflow, output ready);

endinterface

[design/osa_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osa_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module osa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/osa_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osa_ctrl
// Controller: decodes input beats and sequences the per-column row update.
// ----------------------------------------------------------------------------
module osa_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [osa_pkg::FUNC_W-1:0]    in_func,
    output logic                          in_ready,
    input  logic                          out_ready,
    output logic                          out_valid,
    output osa_pkg::cmd_t                 cmd,
    input  osa_pkg::sts_t                 sts
);
    import osa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_func)
                        FUNC_FIRST:
                        begin
                            if (sts.second_zero)
                            begin
                                if (sts.first_full)
                                begin
                                    cmd.set_ovf = 1'b1;
                                end
                                else
                                begin
                                    cmd.load_first = 1'b1;
                                end
                            end
                        end
                        FUNC_SECOND:
                        begin
                            if (sts.second_full)
                            begin
                                cmd.set_ovf = 1'b1;
                            end
                            else
                            begin
                                cmd.row_start = 1'b1;
                                state_next    = sts.first_zero ? S_FIN : S_RD;
                            end
                        end
                        FUNC_END:
                        begin
                            cmd.emit       = 1'b1;
                            out_valid_next = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.cmp    = 1'b1;
                state_next = sts.last_col ? S_FIN : S_RD;
            end
            S_FIN:
            begin
                cmd.row_end = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[design/osa_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osa_dp
// Datapath: first-string store, two cost rows in RAM, one DP column per
// compute step, and the result register.
// ----------------------------------------------------------------------------
module osa_dp #(
    parameter int MAX_LEN = osa_pkg::MAX_LEN_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  osa_pkg::cmd_t                 cmd,
    output osa_pkg::sts_t                 sts,
    input  logic [osa_pkg::SYM_W-1:0]     in_symbol,
    output logic [osa_pkg::DIST_W-1:0]    out_distance,
    output logic                          out_overflow
);
    import osa_pkg::*;

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = LW + 1;
    localparam int EW = (LW > DIST_W) ? LW : DIST_W;

    logic [LW-1:0]    first_len_reg;
    logic [LW-1:0]    second_len_reg;
    logic [SYM_W-1:0] prev_sym_reg;
    logic             ovf_reg;
    logic [SYM_W-1:0] b_reg;
    logic [LW-1:0]    col_reg;
    logic [LW-1:0]    cur_prev_reg;
    logic [LW-1:0]    new_prev_reg;
    logic [LW-1:0]    bd1_reg;
    logic [LW-1:0]    bd2_reg;
    logic [SYM_W-1:0] a_prev_reg;
    logic [LW-1:0]    dist_last_reg;
    logic [DIST_W-1:0] dist_out_reg;
    logic             ovf_out_reg;

    logic [LW-1:0]    col_dec;
    logic [AW-1:0]    col_addr;
    logic [SYM_W-1:0] a_rd;
    logic [LW-1:0]    cur_rd;
    logic [LW-1:0]    bef_rd;
    logic [LW-1:0]    cur_i;
    logic [CW-1:0]    sub_c;
    logic [CW-1:0]    del_c;
    logic [CW-1:0]    ins_c;
    logic [CW-1:0]    trn_c;
    logic [CW-1:0]    best_c;
    logic             trn_ok;
    logic [LW-1:0]    best;
    logic [LW-1:0]    dist_w;
    logic [EW-1:0]    dist_e;

    assign col_dec  = col_reg - LW'(1);
    assign col_addr = col_dec[AW-1:0];

    osa_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_str_ram (
        .clk     (clk),
        .wr_en   (cmd.load_first),
        .wr_addr (first_len_reg[AW-1:0]),
        .wr_data (in_symbol),
        .rd_en   (cmd.rd),
        .rd_addr (col_addr),
        .rd_data (a_rd)
    );

    osa_ram #(.WIDTH(LW), .DEPTH(MAX_LEN)) u_cur_ram (
        .clk     (clk),
        .wr_en   (cmd.cmp),
        .wr_addr (col_addr),
        .wr_data (best),
        .rd_en   (cmd.rd),
        .rd_addr (col_addr),
        .rd_data (cur_rd)
    );

    osa_ram #(.WIDTH(LW), .DEPTH(MAX_LEN)) u_bef_ram (
        .clk     (clk),
        .wr_en   (cmd.cmp),
        .wr_addr (col_addr),
        .wr_data (cur_i),
        .rd_en   (cmd.rd),
        .rd_addr (col_addr),
        .rd_data (bef_rd)
    );

    // first row: the previous row is the column index
    assign cur_i = (second_len_reg == '0) ? col_reg : cur_rd;

    always_comb
    begin
        sub_c  = CW'(cur_prev_reg) + CW'(a_rd != b_reg);
        del_c  = CW'(cur_i) + CW'(1);
        ins_c  = CW'(new_prev_reg) + CW'(1);
        trn_c  = CW'(bd2_reg) + CW'(1);
        trn_ok = (col_reg > LW'(1)) && (second_len_reg != '0)
                 && (a_rd == prev_sym_reg) && (a_prev_reg == b_reg);
        best_c = (del_c < ins_c) ? del_c : ins_c;
        if (sub_c < best_c)
        begin
            best_c = sub_c;
        end
        if (trn_ok && (trn_c < best_c))
        begin
            best_c = trn_c;
        end
        best = best_c[LW-1:0];
    end

    always_comb
    begin
        if (ovf_reg)
        begin
            dist_w = '0;
        end
        else if (second_len_reg == '0)
        begin
            dist_w = first_len_reg;
        end
        else
        begin
            dist_w = dist_last_reg;
        end
        dist_e = EW'(dist_w);
    end

    assign sts.first_zero  = (first_len_reg == '0);
    assign sts.first_full  = (first_len_reg == LW'(MAX_LEN));
    assign sts.second_zero = (second_len_reg == '0);
    assign sts.second_full = (second_len_reg == LW'(MAX_LEN));
    assign sts.last_col    = (col_reg == first_len_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_len_reg  <= '0;
            second_len_reg <= '0;
            prev_sym_reg   <= '0;
            ovf_reg        <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
            begin
                first_len_reg  <= '0;
                second_len_reg <= '0;
                prev_sym_reg   <= '0;
                ovf_reg        <= 1'b0;
            end
            else
            begin
                if (cmd.load_first)
                begin
                    first_len_reg <= first_len_reg + LW'(1);
                end
                if (cmd.set_ovf)
                begin
                    ovf_reg <= 1'b1;
                end
                if (cmd.row_end)
                begin
                    second_len_reg <= second_len_reg + LW'(1);
                    prev_sym_reg   <= b_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.row_start)
        begin
            b_reg        <= in_symbol;
            col_reg      <= LW'(1);
            cur_prev_reg <= second_len_reg;
            new_prev_reg <= second_len_reg + LW'(1);
            bd1_reg      <= second_len_reg - LW'(1);
        end
        if (cmd.cmp)
        begin
            col_reg      <= col_reg + LW'(1);
            cur_prev_reg <= cur_i;
            new_prev_reg <= best;
            bd1_reg      <= bef_rd;
            bd2_reg      <= bd1_reg;
            a_prev_reg   <= a_rd;
        end
        if (cmd.row_end)
        begin
            dist_last_reg <= new_prev_reg;
        end
        if (cmd.emit)
        begin
            dist_out_reg <= (dist_e > EW'(DIST_SAT)) ? DIST_W'(DIST_SAT)
                                                     : dist_e[DIST_W-1:0];
            ovf_out_reg  <= ovf_reg;
        end
    end

    assign out_distance = dist_out_reg;
    assign out_overflow = ovf_out_reg;

endmodule

[design/osa_edit_distance_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osa_edit_distance_top
// Optimal string alignment edit distance between two byte strings.
//
//   channel  dir  payload               handshake
//   in_ch    in   func[1:0] symbol[7:0] valid/ready
//   out_ch   out  distance[6:0] overflow valid/ready
//
// First-string, end and unused beats are handled in the cycle they are accepted.
// A second-string beat runs one DP column per first-string symbol: each
// DP column needs one registered read of the row RAMs and one compute/write.
// No clearing pass after reset; the block is ready in the first cycle.
// The result waits in an output register; input stalls during a row update
// and while a held result waits for ready.
// ----------------------------------------------------------------------------
`include "osa_edit_distance_top_assert.svh"

module osa_edit_distance_top #(
    parameter int MAX_LEN = osa_pkg::MAX_LEN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    osa_in_if.sink     in_ch,
    osa_out_if.source  out_ch
);
    import osa_pkg::*;

    cmd_t cmd;
    sts_t sts;

    osa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_func   (in_ch.func),
        .in_ready  (in_ch.ready),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .cmd       (cmd),
        .sts       (sts)
    );

    osa_dp #(.MAX_LEN(MAX_LEN)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .in_symbol    (in_ch.symbol),
        .out_distance (out_ch.distance),
        .out_overflow (out_ch.overflow)
    );

    `OSA_ASSERT_SAME(a_ovf_zero, out_ch.valid && out_ch.overflow, out_ch.distance == '0, "overflow beat with non-zero distance")
    `OSA_ASSERT_SAME(a_dist_bound, out_ch.valid && !out_ch.overflow, out_ch.distance <= MAX_LEN, "distance beyond maximum length")
    `OSA_ASSERT_SAME(a_hold_input, out_ch.valid && !out_ch.ready, !in_ch.ready, "input taken while result is held")
    `OSA_ASSERT_NEXT(a_end_emits, in_ch.valid && in_ch.ready && (in_ch.func == FUNC_END), out_ch.valid, "end beat gave no result")

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for osa_edit_distance_top. String pairs of random
// content are streamed in; an internal alignment-cost model predicts every
// distance, and each output beat is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import osa_pkg::*;

    localparam int MAX_LEN   = MAX_LEN_DEF;
    localparam int LIMIT     = 1500000;
    localparam int TAIL      = 2 * MAX_LEN + 200;
    localparam int HOLD_LEN  = 400;
    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [SYM_W-1:0]  symbol;
        logic              drain;
    } beat_t;

    typedef struct {
        logic [DIST_W-1:0] distance;
        logic              overflow;
    } alignment_t;

    logic clk;
    logic rst_n;

    osa_in_if  in_ch ();
    osa_out_if out_ch ();

    osa_edit_distance_top #(.MAX_LEN(MAX_LEN)) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    beat_t      beats_pending[$];
    alignment_t dist_due[$];

    // alignment model state
    logic [SYM_W-1:0]  str_a [MAX_LEN];
    int                len_a;
    int                len_b;
    logic [SYM_W-1:0]  last_b;
    logic [DIST_W-1:0] row_now [MAX_LEN+1];
    logic [DIST_W-1:0] row_old [MAX_LEN+1];
    logic              too_long;

    int   beats_taken;
    int   results_seen;
    int   errors;
    int   cycles;
    int   hold_left;
    bit   hold_done;
    int   planned;
    bit   drain_next;
    logic calm;

    assign calm = (beats_taken >= 300) && (beats_taken < 450);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        in_ch.valid  = 1'b0;
        in_ch.func   = FUNC_FIRST;
        in_ch.symbol = '0;
        out_ch.ready = 1'b0;
        rst_n        = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    task automatic clear_alignment();
        len_a    = 0;
        len_b    = 0;
        last_b   = '0;
        too_long = 1'b0;
        for (int k = 0; k <= MAX_LEN; k++)
        begin
            row_now[k] = DIST_W'(k);
            row_old[k] = '0;
        end
    endtask

    task automatic step_alignment(input logic [FUNC_W-1:0] f, input logic [SYM_W-1:0] s);
        int                best;
        int                j;
        int                d;
        logic [DIST_W-1:0] fresh [MAX_LEN+1];
        alignment_t        r;
        case (f)
            FUNC_FIRST:
            begin
                if (len_b == 0)
                begin
                    if (len_a >= MAX_LEN)
                        too_long = 1'b1;
                    else
                    begin
                        str_a[len_a] = s;
                        len_a++;
                    end
                end
            end
            FUNC_SECOND:
            begin
                if (len_b >= MAX_LEN)
                    too_long = 1'b1;
                else
                begin
                    j = len_b + 1;
                    fresh[0] = DIST_W'(j);
                    for (int i = 1; i <= len_a; i++)
                    begin
                        best = int'(row_now[i]) + 1;
                        if (int'(fresh[i-1]) + 1 < best)
                            best = int'(fresh[i-1]) + 1;
                        if (int'(row_now[i-1]) + (str_a[i-1] != s) < best)
                            best = int'(row_now[i-1]) + (str_a[i-1] != s);
                        // adjacent exchange
                        if (i > 1 && j > 1 && str_a[i-1] == last_b && str_a[i-2] == s &&
                            int'(row_old[i-2]) + 1 < best)
                            best = int'(row_old[i-2]) + 1;
                        fresh[i] = DIST_W'(best);
                    end
                    for (int i = 0; i <= len_a; i++)
                    begin
                        row_old[i] = row_now[i];
                        row_now[i] = fresh[i];
                    end
                    last_b = s;
                    len_b  = j;
                end
            end
            FUNC_END:
            begin
                d = too_long ? 0 : int'(row_now[len_a]);
                if (d > DIST_SAT)
                    d = DIST_SAT;
                r.distance = DIST_W'(d);
                r.overflow = too_long;
                dist_due.push_back(r);
                clear_alignment();
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic report(input string what, input int want, input int got);
        errors++;
        if (errors <= 10)
            $display("tb: %s mismatch at %0t: expected %0d, got %0d", what, $time, want, got);
    endtask

    task automatic add_beat(input logic [FUNC_W-1:0] f, input logic [SYM_W-1:0] s);
        beat_t b;
        b.func     = f;
        b.symbol   = s;
        b.drain    = drain_next;
        drain_next = 1'b0;
        beats_pending.push_back(b);
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 6)
            return 0;
        if (r < 86)
            return $urandom_range(8, 1);
        if (r < 96)
            return $urandom_range(MAX_LEN, 9);
        return $urandom_range(MAX_LEN + 2, MAX_LEN);
    endfunction

    // lb < 0: second string is the first one with a few local edits
    task automatic add_pair(input int la, input int lb);
        logic [SYM_W-1:0] sa[$];
        logic [SYM_W-1:0] sb[$];
        logic [SYM_W-1:0] base;
        logic [SYM_W-1:0] t;
        bit               narrow;
        int               p;
        narrow = $urandom_range(3) != 0;
        base   = SYM_W'($urandom_range(255));
        for (int k = 0; k < la; k++)
            sa.push_back(narrow ? base + SYM_W'($urandom_range(2)) : SYM_W'($urandom_range(255)));
        if (lb < 0)
        begin
            sb = sa;
            for (int k = 0; k <= $urandom_range(2); k++)
            begin
                if (sb.size() >= 2)
                begin
                    p = $urandom_range(sb.size() - 2);
                    case ($urandom_range(2))
                        0:
                        begin
                            t       = sb[p];
                            sb[p]   = sb[p+1];
                            sb[p+1] = t;
                        end
                        1: sb[p] = ~sb[p];
                        default: sb.delete(p);
                    endcase
                end
            end
        end
        else
        begin
            for (int k = 0; k < lb; k++)
                sb.push_back(narrow ? base + SYM_W'($urandom_range(2)) :
                             SYM_W'($urandom_range(255)));
        end
        foreach (sa[k])
            add_beat(FUNC_FIRST, sa[k]);
        if ($urandom_range(9) == 0)
            add_beat(FUNC_NONE, SYM_W'($urandom_range(255)));
        foreach (sb[k])
        begin
            add_beat(FUNC_SECOND, sb[k]);
            if (k == 0 && $urandom_range(9) == 0)
                add_beat(FUNC_FIRST, SYM_W'($urandom_range(255)));
        end
        add_beat(FUNC_END, SYM_W'($urandom_range(255)));
        planned += sa.size() + sb.size() + 1;
    endtask

    // stimulus and end of run
    initial
    begin
        int pairs;
        clear_alignment();
        errors       = 0;
        beats_taken  = 0;
        results_seen = 0;
        planned      = 0;
        drain_next   = 1'b0;
        pairs        = 0;

        add_beat(FUNC_END, 8'h00);
        add_beat(FUNC_FIRST, 8'h00);
        add_beat(FUNC_FIRST, 8'hFF);
        add_beat(FUNC_FIRST, 8'h41);
        add_beat(FUNC_END, 8'hFF);
        add_beat(FUNC_SECOND, 8'hFF);
        add_beat(FUNC_SECOND, 8'h00);
        add_beat(FUNC_END, 8'h00);
        add_beat(FUNC_FIRST, 8'h61);
        add_beat(FUNC_FIRST, 8'h62);
        add_beat(FUNC_SECOND, 8'h62);
        add_beat(FUNC_SECOND, 8'h61);
        add_beat(FUNC_END, 8'h00);
        add_beat(FUNC_FIRST, 8'h63);
        add_beat(FUNC_FIRST, 8'h61);
        add_beat(FUNC_SECOND, 8'h61);
        add_beat(FUNC_FIRST, 8'h78);
        add_beat(FUNC_SECOND, 8'h62);
        add_beat(FUNC_NONE, 8'hFF);
        add_beat(FUNC_SECOND, 8'h63);
        add_beat(FUNC_END, 8'h00);
        add_beat(FUNC_FIRST, 8'h80);
        add_beat(FUNC_SECOND, 8'h7F);
        add_beat(FUNC_END, 8'h00);

        // longest strings, then each side running over
        drain_next = 1'b1;
        add_pair(MAX_LEN, MAX_LEN);
        add_pair(MAX_LEN + 1, 2);
        add_pair(3, MAX_LEN + 2);
        while (planned < 900)
        begin
            pairs++;
            drain_next = (pairs % 40) == 0;
            add_pair(pick_len(), $urandom_range(1) ? -1 : pick_len());
        end

        while (beats_pending.size() != 0 || in_ch.valid)
            @(posedge clk);
        while (dist_due.size() != 0)
            @(posedge clk);
        repeat (TAIL) @(posedge clk);
        if (errors == 0 && dist_due.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    // input driver
    always @(posedge clk or negedge rst_n)
    begin : drive
        beat_t nxt;
        bit    fire;
        if (!rst_n)
        begin
            in_ch.valid  <= 1'b0;
            in_ch.func   <= FUNC_FIRST;
            in_ch.symbol <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                step_alignment(in_ch.func, in_ch.symbol);
                beats_taken++;
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                fire = beats_pending.size() != 0 && (calm || $urandom_range(99) >= 7);
                if (fire && beats_pending[0].drain && dist_due.size() != 0)
                    fire = 1'b0;
                if (fire)
                begin
                    nxt = beats_pending.pop_front();
                    in_ch.func   <= nxt.func;
                    in_ch.symbol <= nxt.symbol;
                    in_ch.valid  <= 1'b1;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // long back-pressure stretch, once
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && results_seen >= 20)
        begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin : watch
        alignment_t want;
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                results_seen++;
                if (dist_due.size() == 0)
                    report("unexpected beat", -1, int'(out_ch.distance));
                else
                begin
                    want = dist_due.pop_front();
                    if (out_ch.distance !== want.distance)
                        report("distance", int'(want.distance), int'(out_ch.distance));
                    if (out_ch.overflow !== want.overflow)
                        report("overflow", int'(want.overflow), int'(out_ch.overflow));
                end
            end
            out_ch.ready <= (hold_left == 0) && (calm || $urandom_range(99) >= 7);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial
        cycles = 0;

endmodule

[sim.f]
+incdir+design
design/osa_pkg.sv
design/osa_in_if.sv
design/osa_out_if.sv
design/osa_ram.sv
design/osa_ctrl.sv
design/osa_dp.sv
design/osa_edit_distance_top.sv
sim/tb.sv
